>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the gesture command encoder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in every cycle where ante holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gce_pkg.sv
// ---------------------------------------------------------------------------
// Gesture command encoder package
// Shared types, command codes and register indexes.
// ---------------------------------------------------------------------------
package gce_pkg;

    localparam int AVG_DEPTH_DEF = 10;
    localparam int QUEUE_DEPTH   = 2;
    localparam int NUM_SLOTS     = 5;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_ADDR_W-1:0] REG_BEND_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TILT_LIMIT     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_LIMIT    = 2'd2;

    localparam logic [9:0] BEND_THRESHOLD_RST = 10'd590;
    localparam logic [8:0] TILT_LIMIT_RST     = 9'd30;
    localparam logic [8:0] LEVEL_LIMIT_RST    = 9'd20;

    localparam logic [7:0] CMD_BEND_HIGH = 8'd122;
    localparam logic [7:0] CMD_BEND_LOW  = 8'd123;
    localparam logic [7:0] CMD_TILT_HIGH = 8'd124;
    localparam logic [7:0] CMD_TILT_LOW  = 8'd125;
    localparam logic [7:0] CMD_LEVEL     = 8'd126;

    localparam logic [9:0]        GRIP_LOW     = 10'd550;
    localparam logic [9:0]        GRIP_HIGH    = 10'd650;
    localparam logic signed [9:0] PITCH_HIGH   = -10'sd10;
    localparam logic signed [9:0] PITCH_LOW    = -10'sd50;
    localparam logic [7:0]        PITCH_OFFSET = 8'd60;
    localparam logic [7:0]        PITCH_MAX    = 8'd118;

    localparam int SLOT_BEND  = 0;
    localparam int SLOT_TILT  = 1;
    localparam int SLOT_LEVEL = 2;
    localparam int SLOT_GRIP  = 3;
    localparam int SLOT_PITCH = 4;

    typedef struct packed {
        logic [9:0] bend_threshold;
        logic [8:0] tilt_limit;
        logic [8:0] level_limit;
    } cfg_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]      mask;
        logic [NUM_SLOTS-1:0][7:0] cmd;
    } entry_t;

endpackage

>>> rtl/gesture_command_encoder.sv
// ---------------------------------------------------------------------------
// Gesture command encoder
// Turns flex and angle sample sets into a stream of command bytes.
//
//   Channel  Dir  Beat                                      Marker
//   s_       in   bend_raw, grip_raw, roll_deg, pitch_deg    -
//   m_       out  command                                   tlast = last
//   cfg_     in   bend_threshold, tilt_limit, level_limit   write only
//
// A sample set is classified in the stage 1 and stage 2 registers, waits in
// a two-entry queue, and leaves as zero to five beats, one per cycle from the
// output register while the receiver is ready. Throughput is one sample set
// per cycle up to one beat per cycle out, unless the queue or receiver stalls;
// the back end's single output port sets the rate.
// Reset clears the moving average store, the queue and all valid flags at once.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gesture_command_encoder #(
    parameter int AVG_DEPTH = gce_pkg::AVG_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [gce_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [gce_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // bend_raw[9:0], grip_raw[19:10], roll_deg[29:20], pitch_deg[39:30]
    input  logic [39:0]                     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // command[7:0]
    output logic [7:0]                      m_tdata,
    output logic                            m_tlast
);
    import gce_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   pop_valid;
    logic   pop_ready;
    entry_t pop_entry;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_BEND_THRESHOLD: cfg_next.bend_threshold = cfg_wdata;
                REG_TILT_LIMIT:     cfg_next.tilt_limit     = cfg_wdata[8:0];
                REG_LEVEL_LIMIT:    cfg_next.level_limit    = cfg_wdata[8:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bend_threshold <= BEND_THRESHOLD_RST;
            cfg_reg.tilt_limit     <= TILT_LIMIT_RST;
            cfg_reg.level_limit    <= LEVEL_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    gce_front #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .bend_raw  (s_tdata[9:0]),
        .grip_raw  (s_tdata[19:10]),
        .roll_deg  (s_tdata[29:20]),
        .pitch_deg (s_tdata[39:30]),
        .out_valid (push_valid),
        .out_ready (push_ready),
        .out_entry (push_entry)
    );

    gce_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    gce_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (pop_valid),
        .in_ready    (pop_ready),
        .in_entry    (pop_entry),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_command (m_tdata),
        .out_last    (m_tlast)
    );

    `ASSERT_IMPLIES(a_push_not_empty, aclk, aresetn, push_valid, push_entry.mask != '0, "empty command list pushed")

    `ASSERT_IMPLIES(a_pitch_range, aclk, aresetn, push_valid && push_entry.mask[SLOT_PITCH], (push_entry.cmd[SLOT_PITCH] > PITCH_OFFSET) && (push_entry.cmd[SLOT_PITCH] <= PITCH_MAX), "pitch command out of range")

    `ASSERT_NEXT(a_beat_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output beat changed while stalled")

    `ASSERT_IMPLIES(a_cmd_range, aclk, aresetn, m_tvalid, m_tdata <= CMD_LEVEL, "command byte out of range")

endmodule

>>> rtl/gce_front.sv
// ---------------------------------------------------------------------------
// Gesture command encoder front end
// Accepts sample sets, keeps the grip moving average and classifies each
// sample set into a slot list of up to five command bytes.
// ---------------------------------------------------------------------------
module gce_front #(
    parameter int AVG_DEPTH = gce_pkg::AVG_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  gce_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [9:0]          bend_raw,
    input  logic [9:0]          grip_raw,
    input  logic signed [9:0]   roll_deg,
    input  logic signed [9:0]   pitch_deg,
    output logic                out_valid,
    input  logic                out_ready,
    output gce_pkg::entry_t     out_entry
);
    import gce_pkg::*;

    localparam int DEPTH_LOG = $clog2(AVG_DEPTH);
    localparam int SUM_W     = 10 + DEPTH_LOG;
    localparam int SHIFT     = SUM_W + DEPTH_LOG;
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam longint RECIP = ((64'd1 << SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

    localparam logic [15:0] GRIP_SCALE = 16'd615;
    localparam int          GRIP_SHIFT = 10;

    logic [9:0]        ring_reg [AVG_DEPTH];
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;

    logic              s1_valid_reg;
    logic [9:0]        s1_bend_reg;
    logic signed [9:0] s1_roll_reg;
    logic signed [9:0] s1_pitch_reg;

    logic              s2_valid_reg;
    logic              s2_bend_gt_reg;
    logic              s2_bend_lt_reg;
    logic              s2_tilt_hi_reg;
    logic              s2_tilt_lo_reg;
    logic              s2_level_reg;
    logic              s2_pitch_ok_reg;
    logic [7:0]        s2_pitch_cmd_reg;
    logic [9:0]        s2_avg_reg;

    logic              accept;
    logic              s1_ready;
    logic              s2_ready;
    logic              s2_has_cmd;

    logic signed [10:0] roll_x;
    logic signed [10:0] tilt_x;
    logic signed [10:0] level_x;
    logic [PROD_W-1:0]  avg_prod;
    logic [9:0]         pitch_diff;
    logic [5:0]         pitch_dist;
    logic [7:0]         pitch_tri;
    logic [9:0]         grip_diff;
    logic [15:0]        grip_prod;
    logic               grip_ok;
    entry_t             entry;

    assign s2_has_cmd = |entry.mask;
    assign s2_ready   = !s2_valid_reg || !s2_has_cmd || out_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign in_ready   = s1_ready;
    assign accept     = in_valid && in_ready;
    assign out_valid  = s2_valid_reg && s2_has_cmd;
    assign out_entry  = entry;

    assign sum_next = sum_reg - SUM_W'(ring_reg[AVG_DEPTH-1]) + SUM_W'(grip_raw);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AVG_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
            sum_reg <= '0;
        end else if (accept) begin
            ring_reg[0] <= grip_raw;
            for (int i = 1; i < AVG_DEPTH; i++) begin
                ring_reg[i] <= ring_reg[i-1];
            end
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_bend_reg  <= bend_raw;
            s1_roll_reg  <= roll_deg;
            s1_pitch_reg <= pitch_deg;
        end
    end

    // sum_reg always belongs to the sample set held in stage 1
    assign roll_x   = {s1_roll_reg[9], s1_roll_reg};
    assign tilt_x   = signed'({2'b00, cfg.tilt_limit});
    assign level_x  = signed'({2'b00, cfg.level_limit});
    assign avg_prod = {{RECIP_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, RECIP_C};

    assign pitch_diff = PITCH_HIGH - s1_pitch_reg;
    assign pitch_dist = pitch_diff[5:0];
    assign pitch_tri  = {2'b00, pitch_dist} + {1'b0, pitch_dist, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_bend_gt_reg   <= s1_bend_reg > cfg.bend_threshold;
            s2_bend_lt_reg   <= s1_bend_reg < cfg.bend_threshold;
            s2_tilt_hi_reg   <= roll_x > tilt_x;
            s2_tilt_lo_reg   <= roll_x < -tilt_x;
            s2_level_reg     <= (roll_x < level_x) && (roll_x > -level_x);
            s2_pitch_ok_reg  <= (s1_pitch_reg < PITCH_HIGH) && (s1_pitch_reg > PITCH_LOW);
            s2_pitch_cmd_reg <= {1'b0, pitch_tri[7:1]} + PITCH_OFFSET;
            s2_avg_reg       <= avg_prod[SHIFT +: 10];
        end
    end

    assign grip_ok   = (s2_avg_reg > GRIP_LOW) && (s2_avg_reg < GRIP_HIGH);
    assign grip_diff = s2_avg_reg - GRIP_LOW;
    assign grip_prod = {9'd0, grip_diff[6:0]} * GRIP_SCALE;

    always_comb begin
        entry.mask = '0;
        entry.cmd  = '0;
        entry.mask[SLOT_BEND]  = s2_bend_gt_reg || s2_bend_lt_reg;
        entry.cmd[SLOT_BEND]   = s2_bend_gt_reg ? CMD_BEND_HIGH : CMD_BEND_LOW;
        entry.mask[SLOT_TILT]  = s2_tilt_hi_reg || s2_tilt_lo_reg;
        entry.cmd[SLOT_TILT]   = s2_tilt_hi_reg ? CMD_TILT_HIGH : CMD_TILT_LOW;
        entry.mask[SLOT_LEVEL] = s2_level_reg;
        entry.cmd[SLOT_LEVEL]  = CMD_LEVEL;
        entry.mask[SLOT_GRIP]  = grip_ok;
        entry.cmd[SLOT_GRIP]   = {2'b00, grip_prod[GRIP_SHIFT +: 6]};
        entry.mask[SLOT_PITCH] = s2_pitch_ok_reg;
        entry.cmd[SLOT_PITCH]  = s2_pitch_cmd_reg;
    end

endmodule

>>> rtl/gce_queue.sv
// ---------------------------------------------------------------------------
// Gesture command encoder queue
// Short queue of classified slot lists between front and back end.
// ---------------------------------------------------------------------------
module gce_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  gce_pkg::entry_t  push_entry,
    output logic             pop_valid,
    input  logic             pop_ready,
    output gce_pkg::entry_t  pop_entry
);
    import gce_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    entry_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/gce_back.sv
// ---------------------------------------------------------------------------
// Gesture command encoder back end
// Walks the set slots of each list and sends one command byte per beat.
// ---------------------------------------------------------------------------
module gce_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  gce_pkg::entry_t  in_entry,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_command,
    output logic             out_last
);
    import gce_pkg::*;

    logic [NUM_SLOTS-1:0]      cur_mask_reg;
    logic [NUM_SLOTS-1:0]      cur_mask_next;
    logic [NUM_SLOTS-1:0][7:0] cur_cmd_reg;
    logic                      out_valid_reg;
    logic [7:0]                out_command_reg;
    logic                      out_last_reg;

    logic [NUM_SLOTS-1:0] lowest;
    logic [NUM_SLOTS-1:0] remain;
    logic [7:0]           sel_cmd;
    logic                 out_free;
    logic                 emit;
    logic                 finishing;
    logic                 load;

    assign lowest    = cur_mask_reg & (~cur_mask_reg + 1'b1);
    assign remain    = cur_mask_reg & ~lowest;
    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = out_free && (cur_mask_reg != '0);
    assign finishing = (cur_mask_reg == '0) || (emit && (remain == '0));
    assign load      = in_valid && finishing;
    assign in_ready  = finishing;

    always_comb begin
        sel_cmd = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            sel_cmd = sel_cmd | (cur_cmd_reg[i] & {8{lowest[i]}});
        end
    end

    always_comb begin
        if (load) begin
            cur_mask_next = in_entry.mask;
        end else if (emit) begin
            cur_mask_next = remain;
        end else begin
            cur_mask_next = cur_mask_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_mask_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_mask_reg <= cur_mask_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_cmd_reg <= in_entry.cmd;
        end
        if (emit) begin
            out_command_reg <= sel_cmd;
            out_last_reg    <= remain == '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_command = out_command_reg;
    assign out_last    = out_last_reg;

endmodule

>>> tb/gesture_command_encoder_tb.sv
// ---------------------------------------------------------------------------
// Gesture command encoder testbench
// Drives sample sets into the encoder, predicts the command bytes of each
// accepted beat with an in-bench model of the moving average and the
// threshold mapping, and compares every output beat with the oldest
// predicted byte. Phases run under several register settings, with random
// gaps on both channels, one long receiver hold and idle points between
// phases.
// ---------------------------------------------------------------------------
module gesture_command_encoder_tb;
    import gce_pkg::*;

    localparam int AVG_DEPTH    = AVG_DEPTH_DEF;
    localparam int GRIP_SPAN    = 100;
    localparam int PITCH_SPAN   = 40;
    localparam int ANGLE_SCALE  = 60;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_LIMIT   = 3000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [7:0] command;
        logic       last;
    } cmd_beat_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;

    logic [39:0] pending_samples[$];
    cmd_beat_t   expected_cmds[$];

    logic [9:0]  grip_ring[AVG_DEPTH];
    int          grip_pos;
    int          grip_sum;
    logic [9:0]  thr_bend;
    logic [8:0]  lim_tilt;
    logic [8:0]  lim_level;

    int mismatches  = 0;
    int idle_cycles = 0;
    int tx_gap      = 0;
    int rx_gap      = 0;
    int grip_level  = 600;
    bit tx_idle_en  = 1'b1;
    bit rx_idle_en  = 1'b1;
    bit stall_arm   = 1'b0;
    bit stall_done  = 1'b0;

    gesture_command_encoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [39:0] pack_sample(int bend, int grip, int roll, int pitch);
        return {10'(pitch), 10'(roll), 10'(grip), 10'(bend)};
    endfunction

    function automatic int clamp10u(int v);
        if (v < 0) return 0;
        if (v > 1023) return 1023;
        return v;
    endfunction

    // sample with content steered toward the thresholds and bands
    function automatic logic [39:0] make_sample();
        int bend, grip, roll, pitch, lim;
        if ($urandom_range(0, 14) == 0) grip_level = $urandom_range(480, 720);
        if ($urandom_range(0, 3) == 0) bend = $urandom_range(0, 1023);
        else bend = clamp10u(int'(thr_bend) + int'($urandom_range(0, 6)) - 3);
        if ($urandom_range(0, 6) == 0) grip = $urandom_range(0, 1023);
        else grip = clamp10u(grip_level + int'($urandom_range(0, 80)) - 40);
        case ($urandom_range(0, 4))
            0: roll = $urandom_range(0, 1023);
            1, 2: begin
                lim  = $urandom_range(0, 1) ? int'(lim_tilt) : int'(lim_level);
                roll = lim + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 1)) roll = -roll;
            end
            default: roll = int'($urandom_range(0, 800)) - 400;
        endcase
        if ($urandom_range(0, 9) < 6) pitch = int'($urandom_range(0, 50)) - 55;
        else pitch = $urandom_range(0, 1023);
        return pack_sample(bend, grip, roll, pitch);
    endfunction

    task automatic encode_sample(input logic [39:0] beat);
        logic [7:0] cmds[$];
        int bend, grip, roll, pitch, avg;
        cmd_beat_t cb;
        bend  = beat[9:0];
        grip  = beat[19:10];
        roll  = $signed(beat[29:20]);
        pitch = $signed(beat[39:30]);
        grip_sum = grip_sum - int'(grip_ring[grip_pos]) + grip;
        grip_ring[grip_pos] = grip[9:0];
        grip_pos = (grip_pos == AVG_DEPTH - 1) ? 0 : grip_pos + 1;
        avg = grip_sum / AVG_DEPTH;
        if (bend > int'(thr_bend)) cmds.push_back(CMD_BEND_HIGH);
        if (bend < int'(thr_bend)) cmds.push_back(CMD_BEND_LOW);
        if (roll > int'(lim_tilt)) cmds.push_back(CMD_TILT_HIGH);
        if (roll < -int'(lim_tilt)) cmds.push_back(CMD_TILT_LOW);
        if (roll < int'(lim_level) && roll > -int'(lim_level)) cmds.push_back(CMD_LEVEL);
        if (avg > int'(GRIP_LOW) && avg < int'(GRIP_HIGH))
            cmds.push_back(8'((avg - int'(GRIP_LOW)) * ANGLE_SCALE / GRIP_SPAN));
        if (pitch < int'(PITCH_HIGH) && pitch > int'(PITCH_LOW))
            cmds.push_back(8'((int'(PITCH_HIGH) - pitch) * ANGLE_SCALE / PITCH_SPAN
                              + int'(PITCH_OFFSET)));
        foreach (cmds[i]) begin
            cb.command = cmds[i];
            cb.last    = (i == cmds.size() - 1);
            expected_cmds.push_back(cb);
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        case (idx)
            REG_BEND_THRESHOLD: thr_bend  = 10'(value);
            REG_TILT_LIMIT:     lim_tilt  = 9'(value);
            REG_LEVEL_LIMIT:    lim_level = 9'(value);
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_limits(input int bend, input int tilt, input int level);
        write_reg(REG_BEND_THRESHOLD, bend);
        write_reg(REG_TILT_LIMIT, tilt);
        write_reg(REG_LEVEL_LIMIT, level);
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || s_tvalid || expected_cmds.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random(input int count, input bit tx_idle, input bit rx_idle);
        tx_idle_en = tx_idle;
        rx_idle_en = rx_idle;
        repeat (count) pending_samples.push_back(make_sample());
        drain();
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                encode_sample(s_tdata);
                if (tx_idle_en && $urandom_range(0, 2) == 0) tx_gap = pick_gap();
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    s_tdata  <= pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        cmd_beat_t exp_beat;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected beat: command %0d last %0b", m_tdata, m_tlast);
                end else begin
                    exp_beat = expected_cmds.pop_front();
                    if (m_tdata !== exp_beat.command || m_tlast !== exp_beat.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: command exp %0d got %0d, last exp %0b got %0b",
                                     exp_beat.command, m_tdata, exp_beat.last, m_tlast);
                    end
                end
            end
            if (stall_arm && !stall_done) begin
                stall_done = 1'b1;
                rx_gap     = LONG_HOLD;
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (rx_idle_en && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        foreach (grip_ring[i]) grip_ring[i] = '0;
        grip_pos  = 0;
        grip_sum  = 0;
        thr_bend  = BEND_THRESHOLD_RST;
        lim_tilt  = TILT_LIMIT_RST;
        lim_level = LEVEL_LIMIT_RST;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: boundaries, empty average, zero-result sets
        pending_samples.push_back(pack_sample(590, 0, 0, 0));
        pending_samples.push_back(pack_sample(0, 1023, 511, -512));
        pending_samples.push_back(pack_sample(1023, 1023, -512, 511));
        pending_samples.push_back(pack_sample(591, 1023, 31, -11));
        pending_samples.push_back(pack_sample(589, 1023, -31, -49));
        pending_samples.push_back(pack_sample(590, 1023, 30, -10));
        pending_samples.push_back(pack_sample(590, 1023, -30, -50));
        pending_samples.push_back(pack_sample(590, 1023, 19, -30));
        pending_samples.push_back(pack_sample(590, 1023, -19, -12));
        pending_samples.push_back(pack_sample(590, 1023, 20, 0));
        for (int i = 0; i < 10; i++)
            pending_samples.push_back(pack_sample(1023, 600, (i * 37) % 200 - 100,
                                                  (i % 2) ? -11 : -49));
        pending_samples.push_back(pack_sample(590, 0, -20, 360));
        pending_samples.push_back(pack_sample(590, 0, -21, -360));
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        drain();

        set_limits(0, 0, 0);
        run_random(50, 1'b0, 1'b0);

        set_limits(1023, 360, 360);
        run_random(50, 1'b1, 1'b1);

        // tilt and level bands overlapping
        set_limits(590, 5, 100);
        run_random(60, 1'b1, 1'b1);

        set_limits(512, 30, 20);
        stall_arm = 1'b1;
        run_random(100, 1'b0, 1'b1);

        repeat (3) begin
            set_limits($urandom_range(0, 1023), $urandom_range(0, 360),
                       $urandom_range(0, 360));
            run_random(45, 1'b1, 1'b1);
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
